@@ rtl/core/at2_pkg.sv @@
// Shared constants, types and rounding helper for the atan2 pipeline.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
package at2_pkg;

  localparam int SAMPLE_WIDTH        = 16;
  localparam int ANGLE_FRACTION_BITS = 13;
  localparam int ANGLE_WIDTH         = ANGLE_FRACTION_BITS + 3;

  localparam int MAG_WIDTH  = SAMPLE_WIDTH;
  localparam int REM_WIDTH  = MAG_WIDTH + 1;
  localparam int RATIO_BITS = 16;
  localparam int SQ_WIDTH   = 2 * RATIO_BITS;
  localparam int POLY_FRAC  = 30;
  localparam int ACC_WIDTH  = 32;
  localparam int WIDE_WIDTH = 64;
  localparam int FOLD_WIDTH = POLY_FRAC + 4;
  localparam int OUT_SHIFT  = POLY_FRAC - ANGLE_FRACTION_BITS;

  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES         = RATIO_BITS / DIV_BITS_PER_STAGE;
  localparam int HORNER_STEPS       = 5;
  localparam int POST_STAGES        = 5;

  localparam longint unsigned NANO_SCALE = 64'd1000000000;
  localparam longint unsigned NANO_HALF  = NANO_SCALE / 2;

  localparam longint K5_Q30 = longint'(((64'd13480470 << POLY_FRAC) + NANO_HALF) / NANO_SCALE);
  localparam longint K4_Q30 = longint'(((64'd57477314 << POLY_FRAC) + NANO_HALF) / NANO_SCALE);
  localparam longint K3_Q30 = longint'(((64'd121239071 << POLY_FRAC) + NANO_HALF) / NANO_SCALE);
  localparam longint K2_Q30 = longint'(((64'd195635925 << POLY_FRAC) + NANO_HALF) / NANO_SCALE);
  localparam longint K1_Q30 = longint'(((64'd332994597 << POLY_FRAC) + NANO_HALF) / NANO_SCALE);
  localparam longint K0_Q30 = longint'(((64'd999995630 << POLY_FRAC) + NANO_HALF) / NANO_SCALE);
  localparam longint HALF_PI_Q30 =
    longint'(((64'd1570796327 << POLY_FRAC) + NANO_HALF) / NANO_SCALE);
  localparam longint PI_Q30 =
    longint'(((64'd3141592654 << POLY_FRAC) + NANO_HALF) / NANO_SCALE);

  typedef logic        [MAG_WIDTH-1:0]  mag_t;
  typedef logic        [REM_WIDTH-1:0]  rem_t;
  typedef logic        [RATIO_BITS-1:0] ratio_t;
  typedef logic        [SQ_WIDTH-1:0]   sq_t;
  typedef logic signed [ACC_WIDTH-1:0]  acc_t;
  typedef logic signed [WIDE_WIDTH-1:0] wide_t;
  typedef logic signed [FOLD_WIDTH-1:0] fold_val_t;
  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

  localparam acc_t HORNER_INIT = ACC_WIDTH'(-K5_Q30);
  localparam acc_t HORNER_K [HORNER_STEPS] = '{
    ACC_WIDTH'(K4_Q30), ACC_WIDTH'(-K3_Q30), ACC_WIDTH'(K2_Q30),
    ACC_WIDTH'(-K1_Q30), ACC_WIDTH'(K0_Q30)
  };

  localparam fold_val_t HALF_PI_F      = FOLD_WIDTH'(HALF_PI_Q30);
  localparam fold_val_t PI_F           = FOLD_WIDTH'(PI_Q30);
  localparam fold_val_t PI_LESS_HALF_F = FOLD_WIDTH'(PI_Q30 - HALF_PI_Q30);

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic swap;
  } fold_t;

  typedef struct packed {
    fold_t  fold;
    logic   zero;
    logic   equal;
    rem_t   rem;
    mag_t   dvsr;
    ratio_t quot;
  } div_t;

  typedef struct packed {
    fold_t  fold;
    ratio_t ratio;
    sq_t    sq;
    acc_t   acc;
  } hrn_t;

  // Divide by 2^n, round to nearest, ties away from zero.
  function automatic wide_t rnd_shr(input wide_t v, input int unsigned n);
    wide_t adj;
    adj = v + (64'sd1 <<< (n - 1));
    if (v[WIDE_WIDTH-1]) begin
      adj = adj - 64'sd1;
    end
    return adj >>> n;
  endfunction

endpackage

@@ rtl/core/at2_if.sv @@
// Valid/ready channel interfaces for sample pairs and angle results.
// Depends on at2_pkg for field widths.
`timescale 1ns / 1ps
interface at2_in_if import at2_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] x_coord;
  logic signed [SAMPLE_WIDTH-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface at2_out_if import at2_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

@@ rtl/core/atan2_minimax_deg11_top.sv @@
// Four-quadrant arctangent of signed sample pairs, radians in Q3.13 (pi = 25736).
// One pair is taken every clock unless the pipeline holds; its angle passes
// through one setup stage, four divider stages of four quotient bits each,
// one squaring stage, five two-stage Horner steps and a five-stage multiply,
// fold and round tail ending in the result register. The whole pipeline holds
// while that register carries a result not yet taken; x = y = 0 yields 0.
// Depends on at2_pkg, at2_if, at2_prep, at2_div_stage, at2_horner_stage, at2_post.
`timescale 1ns / 1ps
module atan2_minimax_deg11_top import at2_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  at2_in_if.sink    in_i,
  at2_out_if.source out_o
);

  logic en;
  logic div_valid [DIV_STAGES+1];
  div_t div_stage [DIV_STAGES+1];
  logic hrn_valid [HORNER_STEPS+1];
  hrn_t hrn_stage [HORNER_STEPS+1];
  div_t   last_div;
  ratio_t ratio;
  hrn_t   sq_d, sq_q;
  logic   sq_valid_q;

  // Advance when the result register is empty or being taken.
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  at2_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .x_i     (in_i.x_coord),
    .y_i     (in_i.y_coord),
    .valid_o (div_valid[0]),
    .stage_o (div_stage[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    at2_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_valid[g]),
      .stage_i (div_stage[g]),
      .valid_o (div_valid[g+1]),
      .stage_o (div_stage[g+1])
    );
  end

  assign last_div = div_stage[DIV_STAGES];

  always_comb begin
    if (last_div.zero) begin
      ratio = '0;
    end else if (last_div.equal) begin
      ratio = '1;
    end else begin
      ratio = last_div.quot;
    end
    sq_d.fold  = last_div.fold;
    sq_d.ratio = ratio;
    sq_d.sq    = ratio * ratio;
    sq_d.acc   = HORNER_INIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else if (en) begin
      sq_valid_q <= div_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q <= sq_d;
    end
  end

  assign hrn_valid[0] = sq_valid_q;
  assign hrn_stage[0] = sq_q;

  for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_hrn
    at2_horner_stage u_hrn (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (hrn_valid[h]),
      .stage_i (hrn_stage[h]),
      .coef_i  (HORNER_K[h]),
      .valid_o (hrn_valid[h+1]),
      .stage_o (hrn_stage[h+1])
    );
  end

  at2_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (hrn_valid[HORNER_STEPS]),
    .stage_i (hrn_stage[HORNER_STEPS]),
    .out_o   (out_o)
  );

endmodule

@@ rtl/core/at2_prep.sv @@
// Magnitude, octant and divider setup stage of the atan2 pipeline.
// Depends on at2_pkg.
`timescale 1ns / 1ps
module at2_prep import at2_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [SAMPLE_WIDTH-1:0] x_i,
  input  logic [SAMPLE_WIDTH-1:0] y_i,
  output logic                    valid_o,
  output div_t                    stage_o
);

  mag_t ax, ay, mx, mn;
  div_t stage_d, stage_q;
  logic valid_q;

  always_comb begin
    ax = x_i[SAMPLE_WIDTH-1] ? (~x_i + MAG_WIDTH'(1)) : x_i;
    ay = y_i[SAMPLE_WIDTH-1] ? (~y_i + MAG_WIDTH'(1)) : y_i;
    stage_d.fold.x_neg = x_i[SAMPLE_WIDTH-1];
    stage_d.fold.y_neg = y_i[SAMPLE_WIDTH-1];
    stage_d.fold.swap  = (ay > ax);
    mx = stage_d.fold.swap ? ay : ax;
    mn = stage_d.fold.swap ? ax : ay;
    stage_d.zero  = (mx == '0);
    stage_d.equal = (mn == mx);
    stage_d.rem   = {1'b0, mn};
    stage_d.dvsr  = mx;
    stage_d.quot  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ rtl/core/at2_div_stage.sv @@
// One registered slice of the restoring ratio divider: four quotient bits.
// Depends on at2_pkg.
`timescale 1ns / 1ps
module at2_div_stage import at2_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t stage_i,
  output logic valid_o,
  output div_t stage_o
);

  div_t stage_d, stage_q;
  rem_t shifted;
  logic valid_q;

  always_comb begin
    stage_d = stage_i;
    shifted = '0;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      shifted = {stage_d.rem[REM_WIDTH-2:0], 1'b0};
      if (shifted >= {1'b0, stage_d.dvsr}) begin
        stage_d.rem  = shifted - {1'b0, stage_d.dvsr};
        stage_d.quot = {stage_d.quot[RATIO_BITS-2:0], 1'b1};
      end else begin
        stage_d.rem  = shifted;
        stage_d.quot = {stage_d.quot[RATIO_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ rtl/core/at2_horner_stage.sv @@
// One Horner step in s: registered multiply, then round and add coefficient.
// Depends on at2_pkg.
`timescale 1ns / 1ps
module at2_horner_stage import at2_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  hrn_t stage_i,
  input  acc_t coef_i,
  output logic valid_o,
  output hrn_t stage_o
);

  logic signed [SQ_WIDTH:0] sq_ext;
  wide_t prod_d, prod_q;
  hrn_t  mid_q, stage_d, stage_q;
  logic  mid_valid_q, valid_q;

  assign sq_ext = $signed({1'b0, stage_i.sq});
  assign prod_d = stage_i.acc * sq_ext;

  always_comb begin
    stage_d     = mid_q;
    stage_d.acc = ACC_WIDTH'(rnd_shr(prod_q, SQ_WIDTH)) + coef_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      valid_q     <= 1'b0;
    end else if (en_i) begin
      mid_valid_q <= valid_i;
      valid_q     <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      mid_q   <= stage_i;
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ rtl/core/at2_post.sv @@
// Final multiply by the ratio, octant fold, output rounding and result register.
// Depends on at2_pkg and at2_out_if.
`timescale 1ns / 1ps
module at2_post import at2_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  hrn_t stage_i,
  at2_out_if.source out_o
);

  logic signed [RATIO_BITS:0] ratio_ext;
  logic [POST_STAGES-1:0] vld_q;
  wide_t     prod_d, prod_q;
  fold_t     fold1_q, fold2_q;
  logic      y_neg3_q, y_neg4_q;
  fold_val_t v_d, v_q, w_d, w_q;
  angle_t    r_d, r_q, angle_d, angle_q;

  assign ratio_ext = $signed({1'b0, stage_i.ratio});
  assign prod_d    = stage_i.acc * ratio_ext;
  assign v_d       = FOLD_WIDTH'(rnd_shr(prod_q, RATIO_BITS));

  always_comb begin
    if (fold2_q.swap && !fold2_q.x_neg) begin
      w_d = HALF_PI_F - v_q;
    end else if (!fold2_q.swap && fold2_q.x_neg) begin
      w_d = PI_F - v_q;
    end else if (fold2_q.swap && fold2_q.x_neg) begin
      w_d = PI_LESS_HALF_F + v_q;
    end else begin
      w_d = v_q;
    end
  end

  assign r_d     = ANGLE_WIDTH'(rnd_shr(WIDE_WIDTH'(w_q), OUT_SHIFT));
  assign angle_d = y_neg4_q ? -r_q : r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[POST_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      fold1_q  <= stage_i.fold;
      v_q      <= v_d;
      fold2_q  <= fold1_q;
      w_q      <= w_d;
      y_neg3_q <= fold2_q.y_neg;
      r_q      <= r_d;
      y_neg4_q <= y_neg3_q;
      angle_q  <= angle_d;
    end
  end

  assign out_o.valid = vld_q[POST_STAGES-1];
  assign out_o.angle = angle_q;

endmodule
